/* src/xxtea_pkg.sv */
`timescale 1ns / 1ps

package xxtea_pkg;

  localparam logic [31:0] TEA_DELTA     = 32'h9e37_79b9;
  localparam int          ROUND_BASE    = 6;
  localparam int          ROUND_SPAN    = 52;
  localparam int          ROUNDS_W      = 6;
  localparam int          REM_W         = 6;
  localparam int          DEF_MAX_WORDS = 64;
  localparam int          CFG_INDEX_W   = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3 = CFG_INDEX_W'(3);

  // xxtea mix function with unsigned shifts
  function automatic logic [31:0] xxtea_mix(
    input logic [31:0] y,
    input logic [31:0] z,
    input logic [31:0] sum,
    input logic [31:0] key
  );
    logic [31:0] lhs;
    logic [31:0] rhs;
    lhs = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    rhs = (sum ^ y) + (key ^ z);
    return lhs ^ rhs;
  endfunction

endpackage

/* src/xxtea_block_cipher.sv */
`timescale 1ns / 1ps
// a block of n words goes through round-count division (6 + 52/n rounds), setup, then
// (6 + 52/n) * n mix steps, each reading a word and its ring neighbor and writing the word
// back, then emission of each word; an error result is emitted after the final word, once
// the output is free. input words are taken one per cycle while collecting; no input is
// taken while a block is being processed or emitted. reset clears control state and the
// key registers; the word memory is not cleared and needs no clearing pass.
module xxtea_block_cipher
  import xxtea_pkg::*;
#(
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [31:0]            word_in,
  input  logic                   end_of_block,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            word_out,
  output logic                   last_out,
  output logic                   block_error
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int QW = (CW > REM_W) ? CW : REM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SETUP,
    S_INIT,
    S_RD,
    S_MIX,
    S_ERD,
    S_ELD,
    S_ERR
  } state_t;

  state_t state;

  logic [31:0]         key [4];
  logic [31:0]         word_store [MAX_WORDS];
  logic [CW-1:0]       word_count;
  logic                overflow_seen;
  logic [CW-1:0]       n;
  logic                decrypt;
  logic [REM_W-1:0]    rem;
  logic [ROUNDS_W-1:0] rounds;
  logic [31:0]         sum;
  logic [31:0]         chain;
  logic [AW-1:0]       p;

  logic [31:0]         rd_a;
  logic [31:0]         rd_b;
  logic [AW-1:0]       raddr_b;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [31:0]         mem_wdata;

  logic                in_take;
  logic                out_free;
  logic                has_room;
  logic [CW-1:0]       n_next;
  logic                bad_block;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       neighbor;
  logic [1:0]          kidx;
  logic [31:0]         mix_val;
  logic [31:0]         step_res;
  logic                rem_fits;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign has_room  = (word_count < CW'(MAX_WORDS));
  assign n_next    = has_room ? word_count + CW'(1) : word_count;
  assign bad_block = !has_room || overflow_seen || (n_next < CW'(2));
  assign last_idx  = AW'(n - CW'(1));
  assign rem_fits  = (QW'(rem) >= QW'(n));

  // read address of the ring neighbor of the word updated by the current step, or of the chain seed during setup
  always_comb begin
    if (!decrypt) begin
      neighbor = (p == last_idx) ? '0 : p + AW'(1);
    end else begin
      neighbor = (p == '0) ? last_idx : p - AW'(1);
    end
    raddr_b = neighbor;
    if (state == S_SETUP) begin
      raddr_b = decrypt ? '0 : last_idx;
    end
  end

  assign kidx     = 2'(p) ^ sum[3:2];
  assign mix_val  = decrypt ? xxtea_mix(chain, rd_b, sum, key[kidx])
                            : xxtea_mix(rd_b, chain, sum, key[kidx]);
  assign step_res = decrypt ? rd_a - mix_val : rd_a + mix_val;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p;
    mem_wdata = step_res;
    if (state == S_IDLE) begin
      mem_we    = in_take && has_room;
      mem_waddr = word_count[AW-1:0];
      mem_wdata = word_in;
    end else if (state == S_MIX) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_store[mem_waddr] <= mem_wdata;
    end
    rd_a <= word_store[p];
    rd_b <= word_store[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        KEY_WORD_0: key[0] <= cfg_data;
        KEY_WORD_1: key[1] <= cfg_data;
        KEY_WORD_2: key[2] <= cfg_data;
        KEY_WORD_3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      word_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            word_count <= n_next;
            if (!has_room) begin
              overflow_seen <= 1'b1;
            end
            if (end_of_block) begin
              word_count    <= '0;
              overflow_seen <= 1'b0;
              n             <= n_next;
              decrypt       <= mode;
              rem           <= REM_W'(ROUND_SPAN);
              rounds        <= ROUNDS_W'(ROUND_BASE);
              state         <= bad_block ? S_ERR : S_DIV;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            word_out    <= '0;
            last_out    <= 1'b1;
            block_error <= 1'b1;
            state       <= S_IDLE;
          end
        end
        // rounds = 6 + 52 / n by repeated subtraction
        S_DIV: begin
          if (rem_fits) begin
            rem    <= REM_W'(QW'(rem) - QW'(n));
            rounds <= rounds + ROUNDS_W'(1);
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          sum   <= decrypt ? 32'(32'(rounds) * TEA_DELTA) : TEA_DELTA;
          p     <= decrypt ? last_idx : '0;
          state <= S_INIT;
        end
        S_INIT: begin
          chain <= rd_b;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_MIX;
        end
        S_MIX: begin
          chain <= step_res;
          state <= S_RD;
          if ((!decrypt && p == last_idx) || (decrypt && p == '0)) begin
            rounds <= rounds - ROUNDS_W'(1);
            sum    <= decrypt ? sum - TEA_DELTA : sum + TEA_DELTA;
            p      <= decrypt ? last_idx : '0;
            if (rounds == ROUNDS_W'(1)) begin
              p     <= '0;
              state <= S_ERD;
            end
          end else begin
            p <= decrypt ? p - AW'(1) : p + AW'(1);
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            word_out    <= rd_a;
            last_out    <= (p == last_idx);
            block_error <= 1'b0;
            if (p == last_idx) begin
              state <= S_IDLE;
            end else begin
              p     <= p + AW'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_error |-> last_out && word_out == '0)
    else $error("error result must be a lone last word of zero");

  a_step_in_block: assert property (@(posedge clk) disable iff (rst)
    state == S_MIX |-> p <= last_idx && n >= CW'(2))
    else $error("mix step outside the block");

  a_rounds_left: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> rounds != '0)
    else $error("mix step with no round left");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_MIX |=> !mem_we || state == S_RD)
    else $error("memory written outside a mix step or collection");
`endif

endmodule
